>>> hw/rtl/kwm_pkg.sv
// Shared types and constants for the k-way merge core.
// Holds the stream field layout, status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package kwm_pkg;

   // Default configuration of the core.
   localparam int NUM_LISTS_DEF   = 8;
   localparam int LIST_DEPTH_DEF  = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed stream field widths.
   localparam int INDEX_FIELD_W  = 3;
   localparam int VALUE_FIELD_W  = 32;
   localparam int STATUS_FIELD_W = 2;
   localparam int REQ_DATA_W     = 40;
   localparam int RSP_DATA_W     = 40;

   // Kind of request item, carried on req_tuser.
   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   // Result status codes, carried on rsp_tuser.
   typedef enum logic [STATUS_FIELD_W-1:0] {
      RSP_DONE  = 2'd0,
      RSP_FULL  = 2'd1,
      RSP_EMPTY = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_SCAN,
      ST_SETTLE,
      ST_COMMIT
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_req;     // capture request fields, restart the head scan
      logic scan_step;    // read the head of the next list
      logic push_commit;  // append or drop the pushed value, load the result
      logic pop_commit;   // remove the winning head, load the result
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic scan_last;    // the scan points at the last list
      logic out_free;     // result register can take a new result this cycle
   } dp_status_type;

endpackage : kwm_pkg

`default_nettype wire

>>> hw/rtl/kwm_dp.sv
// Datapath of the k-way merge core: list memory, per-list pointers and fill
// counts, head scan comparator and result register. Uses kwm_pkg.
`default_nettype none

module kwm_dp #(
   parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
   parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  kwm_pkg::cmd_type             cmd,
   output kwm_pkg::dp_status_type       st,
   input  wire [kwm_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [kwm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [kwm_pkg::STATUS_FIELD_W-1:0] rsp_tuser
);
   import kwm_pkg::*;

   localparam int LIDX_W = $clog2(NUM_LISTS);
   localparam int PTR_W  = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_LISTS * LIST_DEPTH;
   localparam int ADDR_W = $clog2(MEM_DEPTH);

   // Captured request fields.
   logic [INDEX_FIELD_W-1:0]        idx_ff;
   logic signed [VALUE_FIELD_W-1:0] val_ff;

   // Per-list state.
   logic [PTR_W-1:0] rp_ff   [NUM_LISTS];
   logic [PTR_W-1:0] wp_ff   [NUM_LISTS];
   logic [CNT_W-1:0] fill_ff [NUM_LISTS];

   // List store; its contents are undefined until written.
   logic [VALUE_WIDTH-1:0] mem [MEM_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // Scan state.
   logic [LIDX_W-1:0]      scan_ff;
   logic                   rd_vld_ff;
   logic                   rd_nonempty_ff;
   logic [LIDX_W-1:0]      rd_idx_ff;
   logic                   found_ff;
   logic [VALUE_WIDTH-1:0] best_val_ff;
   logic [LIDX_W-1:0]      best_idx_ff;

   // Result register.
   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [VALUE_FIELD_W-1:0]  rsp_value_ff;
   logic [INDEX_FIELD_W-1:0]  rsp_source_ff;

   logic [LIDX_W-1:0]      push_idx;
   logic                   push_ok;
   logic [LIDX_W-1:0]      sel_idx;
   logic [PTR_W-1:0]       sel_rp;
   logic [PTR_W-1:0]       sel_wp;
   logic [CNT_W-1:0]       sel_fill;
   logic [ADDR_W-1:0]      base_addr;
   logic [ADDR_W-1:0]      rd_addr;
   logic [ADDR_W-1:0]      wr_addr;
   logic [PTR_W-1:0]       rp_in;
   logic [PTR_W-1:0]       wp_in;
   logic                   take;
   logic                   out_free;
   logic [VALUE_WIDTH-1:0] store_val;

   // One list is addressed at a time: the scanned list, the pushed list or
   // the winning list of a pop.
   always_comb begin
      push_idx = LIDX_W'(idx_ff);
      push_ok  = 1'b0;
      if (int'(idx_ff) < NUM_LISTS) begin
         push_ok = 1'b1;
      end
      if (cmd.scan_step) begin
         sel_idx = scan_ff;
      end else if (cmd.push_commit) begin
         sel_idx = push_idx;
      end else begin
         sel_idx = best_idx_ff;
      end
      sel_rp   = rp_ff[sel_idx];
      sel_wp   = wp_ff[sel_idx];
      sel_fill = fill_ff[sel_idx];
      if (push_ok && (sel_fill >= CNT_W'(LIST_DEPTH))) begin
         push_ok = 1'b0;
      end
      base_addr = ADDR_W'(sel_idx) * ADDR_W'(LIST_DEPTH);
      rd_addr   = base_addr + ADDR_W'(sel_rp);
      wr_addr   = base_addr + ADDR_W'(sel_wp);
      rp_in = (sel_rp == PTR_W'(LIST_DEPTH - 1)) ? '0 : sel_rp + 1'b1;
      wp_in = (sel_wp == PTR_W'(LIST_DEPTH - 1)) ? '0 : sel_wp + 1'b1;
      store_val = VALUE_WIDTH'(val_ff);
   end

   // Capture the request fields at the input transfer.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         idx_ff <= req_tdata[INDEX_FIELD_W-1:0];
         val_ff <= req_tdata[INDEX_FIELD_W +: VALUE_FIELD_W];
      end
   end

   // List store: one write port for pushes, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (cmd.push_commit && push_ok) begin
         mem[wr_addr] <= store_val;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Pointers and fill counts of the addressed list.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LISTS; i++) begin
            rp_ff[i]   <= '0;
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cmd.push_commit && push_ok) begin
         wp_ff[sel_idx]   <= wp_in;
         fill_ff[sel_idx] <= sel_fill + 1'b1;
      end else if (cmd.pop_commit && found_ff) begin
         rp_ff[sel_idx]   <= rp_in;
         fill_ff[sel_idx] <= sel_fill - 1'b1;
      end
   end

   // Head scan: one list per cycle, compared in the cycle after its read.
   assign take = rd_vld_ff && rd_nonempty_ff &&
                 (!found_ff || ($signed(rd_data_ff) < $signed(best_val_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_step;
         if (cmd.load_req) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.scan_step) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_nonempty_ff <= (sel_fill != '0);
      rd_idx_ff      <= scan_ff;
      if (take) begin
         best_val_ff <= rd_data_ff;
         best_idx_ff <= rd_idx_ff;
      end
   end

   // Result register: loaded at a commit, emptied by an output transfer.
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push_commit || cmd.pop_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_commit) begin
         rsp_status_ff <= push_ok ? RSP_DONE : RSP_FULL;
         rsp_value_ff  <= '0;
         rsp_source_ff <= '0;
      end else if (cmd.pop_commit) begin
         if (found_ff) begin
            rsp_status_ff <= RSP_DONE;
            rsp_value_ff  <= VALUE_FIELD_W'(best_val_ff);
            rsp_source_ff <= INDEX_FIELD_W'(best_idx_ff);
         end else begin
            rsp_status_ff <= RSP_EMPTY;
            rsp_value_ff  <= '0;
            rsp_source_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_FIELD_W - INDEX_FIELD_W){1'b0}},
                        rsp_source_ff, rsp_value_ff};

   assign st.scan_last = (scan_ff == LIDX_W'(NUM_LISTS - 1));
   assign st.out_free  = out_free;

   // A scanned list never holds more than its depth.
   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (sel_fill <= CNT_W'(LIST_DEPTH)))
      else $error("list fill count above depth");

   // A result is loaded only when the result register can take it.
   a_commit_free : assert property (@(posedge clock) disable iff (reset)
      (cmd.push_commit || cmd.pop_commit) |-> out_free)
      else $error("result loaded over a waiting result");

   // A pop that found no head reports all lists empty.
   a_pop_empty : assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_commit && !found_ff) |=> (rsp_status_ff == RSP_EMPTY))
      else $error("empty pop not reported as empty");

endmodule : kwm_dp

`default_nettype wire

>>> hw/rtl/kwm_ctrl.sv
// Controller of the k-way merge core: sequences request capture, push
// commit, and the head scan and commit of a pop. Uses kwm_pkg.
`default_nettype none

module kwm_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire                    req_tuser,
   input  kwm_pkg::dp_status_type st,
   output kwm_pkg::cmd_type       cmd
);
   import kwm_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in = (req_tuser == KIND_POP) ? ST_SCAN : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (st.out_free) begin
               cmd.push_commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (st.scan_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (st.out_free) begin
               cmd.pop_commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // At most one command per cycle.
   a_cmd_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.scan_step, cmd.push_commit, cmd.pop_commit}))
      else $error("more than one command issued");

   // The last list read is followed by the settle cycle.
   a_scan_end : assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && st.scan_last) |=> (state_ff == ST_SETTLE))
      else $error("scan did not end after the last list");

   // A captured request leaves idle at once.
   a_load_leaves : assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> (state_ff == ST_PUSH || state_ff == ST_SCAN))
      else $error("request captured without starting work");

endmodule : kwm_ctrl

`default_nettype wire

>>> hw/rtl/k_way_sorted_merge_core.sv
// K-way merge core: NUM_LISTS FIFOs of LIST_DEPTH signed values; a push
// (req_tuser 0) appends to list req_tdata[2:0], or reports the list full and
// drops the value; a pop (req_tuser 1) returns the smallest head over all
// lists, lowest list on ties, or reports all lists empty. Every request gives
// exactly one response, status on rsp_tuser. A push is captured at the input
// transfer and committed in the PUSH state; a pop is captured, scans the list
// heads in the SCAN state, passes SETTLE and is committed in the COMMIT state.
// The pop reads one list head per cycle through the single read port of the
// list memory and compares it on a shared comparator. One request is in work
// at a time. A new one is taken while the previous result still waits in the
// output register, but its commit then holds until that result is read, and
// no further input transfer is taken meanwhile.
// Depends on kwm_pkg, kwm_ctrl and kwm_dp.
`default_nettype none

module k_way_sorted_merge_core #(
   parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
   parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
   parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // Request channel.
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [kwm_pkg::REQ_DATA_W-1:0]       req_tdata,  // list_index[2:0], value[34:3]
   input  wire                                 req_tuser,  // kind
   // Response channel.
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [kwm_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // merged_value[31:0], source_list[34:32]
   output logic [kwm_pkg::STATUS_FIELD_W-1:0]  rsp_tuser   // status[1:0]
);
   import kwm_pkg::*;

   cmd_type       cmd;
   dp_status_type st;

   // Sequencer.
   kwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   // Lists, scan and result register.
   kwm_dp #(
      .NUM_LISTS   (NUM_LISTS),
      .LIST_DEPTH  (LIST_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule : k_way_sorted_merge_core

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for k_way_sorted_merge_core: push and pop requests with random
// handshake gaps, each response checked against an in-bench model of the eight lists.
// Depends on kwm_pkg and the k_way_sorted_merge_core RTL.
module tb;
   import kwm_pkg::*;

   localparam int LISTS          = NUM_LISTS_DEF;
   localparam int DEPTH          = LIST_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_REPORTS    = 60;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

   // One response as the core should return it.
   typedef struct packed {
      status_type         status;
      logic signed [31:0] value;
      logic [2:0]         src;
   } merge_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // list_index[2:0], value[34:3]
   logic                  req_tuser  = 1'b0;  // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // merged_value[31:0], source_list[34:32]
   logic [STATUS_FIELD_W-1:0] rsp_tuser;  // status[1:0]

   // Mirror of the list storage inside the core.
   logic signed [31:0] list_mem [LISTS][DEPTH];
   logic [3:0]         head_ptr [LISTS];
   logic [3:0]         tail_ptr [LISTS];
   logic [4:0]         fill     [LISTS];
   logic signed [31:0] last_pushed [LISTS];

   merge_result_type merge_results_q[$];

   int  idle_pct   = 0;
   bit  no_idle    = 1'b0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  n_push_ok = 0, n_push_full = 0, n_pop_ok = 0, n_pop_empty = 0;
   int  n_checked = 0, n_fail = 0;

   k_way_sorted_merge_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one accepted request to the list mirror and queue the response it should give.
   function automatic void merge_step(input logic kind, input logic [2:0] idx,
                                      input logic signed [31:0] value);
      merge_result_type res;
      bit            found;
      int            best;
      logic signed [31:0] best_val;
      res   = '{status: RSP_DONE, value: '0, src: '0};
      found = 1'b0;
      best  = 0;
      best_val = '0;
      if (kind == KIND_PUSH) begin
         if (int'(idx) >= LISTS || fill[idx] >= 5'(DEPTH)) begin
            res.status = RSP_FULL;
            n_push_full++;
         end else begin
            list_mem[idx][tail_ptr[idx]] = value;
            tail_ptr[idx] = tail_ptr[idx] + 4'd1;
            fill[idx]     = fill[idx] + 5'd1;
            n_push_ok++;
         end
      end else begin
         // Strict less-than keeps the lowest list on equal heads.
         for (int i = 0; i < LISTS; i++) begin
            if (fill[i] != 0 && (!found || list_mem[i][head_ptr[i]] < best_val)) begin
               found    = 1'b1;
               best     = i;
               best_val = list_mem[i][head_ptr[i]];
            end
         end
         if (!found) begin
            res.status = RSP_EMPTY;
            n_pop_empty++;
         end else begin
            res.value      = best_val;
            res.src        = 3'(best);
            head_ptr[best] = head_ptr[best] + 4'd1;
            fill[best]     = fill[best] - 5'd1;
            n_pop_ok++;
         end
      end
      merge_results_q.insert(merge_results_q.size(), res);
   endfunction

   // Drive one request and hold it until the core takes the transfer. Called at a falling edge.
   task automatic send_item(input logic kind, input logic [2:0] idx,
                            input logic signed [31:0] value);
      int gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(18, 1);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {5'b0, value, idx};
      do @(posedge clock); while (!req_tready);
      merge_step(kind, idx, value);
      if (kind == KIND_PUSH) last_pushed[idx] = value;
      @(negedge clock);
   endtask

   // Next value for a list: mostly nondecreasing after its last push, now and then anything.
   function automatic logic signed [31:0] next_push_value(input logic [2:0] idx);
      longint sum;
      longint step;
      int     pick;
      if (fill[idx] == 0) begin
         pick = $urandom_range(99);
         if (pick < 55) return $urandom;
         if (pick < 85) return 32'($signed($urandom_range(4)) - 2);
         return ($urandom_range(1)) ? VAL_MIN : VAL_MAX;
      end
      if ($urandom_range(99) < 8) return $urandom;
      case ($urandom_range(3))
         0: step = 0;
         1: step = $urandom_range(4);
         2: step = $urandom_range(1000);
         default: step = longint'($urandom);
      endcase
      sum = longint'(last_pushed[idx]) + step;
      if (sum > longint'(VAL_MAX)) sum = longint'(VAL_MAX);
      return 32'(sum);
   endfunction

   // A run of random requests with a given mix of pushes and pops.
   task automatic random_phase(input int count, input int push_pct, input bit focused);
      logic [2:0] idx;
      logic [2:0] focus;
      focus = 3'($urandom_range(7));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < push_pct) begin
            idx = (focused && $urandom_range(99) < 70) ? focus : 3'($urandom_range(7));
            send_item(KIND_PUSH, idx, next_push_value(idx));
         end else begin
            send_item(KIND_POP, 3'($urandom_range(7)), $urandom);
         end
      end
   endtask

   // Pop with every list empty right after reset.
   task automatic test_empty_pop();
      send_item(KIND_POP, 3'd7, VAL_MAX);
   endtask

   // Fill one list to its depth with extreme values, then push once more.
   task automatic test_full_list();
      logic signed [31:0] fill_vals [16];
      fill_vals = '{VAL_MIN, VAL_MIN, -32'sd1000, -32'sd2, -32'sd1, -32'sd1, 32'sd0, 32'sd0,
                    32'sd1, 32'sd2, 32'sd1000, 32'sh4000_0000, VAL_MAX - 1, VAL_MAX,
                    VAL_MAX, VAL_MAX};
      for (int i = 0; i < DEPTH; i++) send_item(KIND_PUSH, 3'd6, fill_vals[i]);
      send_item(KIND_PUSH, 3'd6, 32'sd5);
   endtask

   // Three lists with the same smallest head: pops must come out lowest list first.
   task automatic test_equal_heads();
      send_item(KIND_PUSH, 3'd7, VAL_MIN);
      send_item(KIND_PUSH, 3'd0, VAL_MIN);
      repeat (3) send_item(KIND_POP, 3'd0, '0);
   endtask

   // Random mix of filling, draining and focused phases with gaps on both sides.
   task automatic test_random_merge();
      int mixes [6] = '{85, 50, 20, 90, 45, 15};
      for (int p = 0; p < 6; p++) begin
         idle_pct = (p == 3) ? 0 : $urandom_range(40, 10);
         random_phase(70, mixes[p], p == 3 || p == 0);
      end
   endtask

   // Stop sending until every response has come back, then resume.
   task automatic test_pause_until_drained();
      idle_pct = 20;
      random_phase(30, 70, 1'b0);
      req_tvalid = 1'b0;
      while (merge_results_q.size() != 0) @(negedge clock);
      random_phase(30, 40, 1'b0);
   endtask

   // Back-to-back transfers with no idling on either side.
   task automatic test_back_to_back();
      idle_pct = 0;
      no_idle  = 1'b1;
      random_phase(50, 75, 1'b1);
      random_phase(50, 30, 1'b0);
   endtask

   // Response side stalls in random bursts, with ready stretches in between; always ready when no_idle is set.
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_tready = 1'b1;
      end else begin
         if (stall_left == 0) begin
            if ($urandom_range(99) < 35) begin
               rsp_tready = 1'b0;
               stall_left = $urandom_range(18, 1);
            end else begin
               rsp_tready = 1'b1;
               stall_left = ($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                                     : $urandom_range(30, 1);
            end
         end
         stall_left--;
      end
   end

   // Compare each response transfer with the oldest outstanding expectation.
   always @(posedge clock) begin
      merge_result_type exp_res;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_checked++;
         if (merge_results_q.size() == 0) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) $error("response transfer with no request outstanding");
         end else begin
            exp_res = merge_results_q.pop_front();
            if (rsp_tuser !== exp_res.status) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS)
                  $error("status: expected %0d, actual %0d", exp_res.status, rsp_tuser);
            end
            if (rsp_tdata[31:0] !== exp_res.value) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS)
                  $error("merged_value: expected %0d, actual %0d", exp_res.value,
                         $signed(rsp_tdata[31:0]));
            end
            if (rsp_tdata[34:32] !== exp_res.src) begin
               n_fail++;
               if (n_fail <= MAX_REPORTS)
                  $error("source_list: expected %0d, actual %0d", exp_res.src,
                         rsp_tdata[34:32]);
            end
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either side for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < LISTS; i++) begin
         head_ptr[i]    = '0;
         tail_ptr[i]    = '0;
         fill[i]        = '0;
         last_pushed[i] = '0;
      end
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_empty_pop();
      test_full_list();
      test_equal_heads();
      test_random_merge();
      test_pause_until_drained();
      test_back_to_back();

      // Let every outstanding response drain, then watch for stray ones.
      req_tvalid = 1'b0;
      while (merge_results_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d stored pushes, %0d pushes dropped on a full list,",
               n_push_ok, n_push_full);
      $display("%0d pops, %0d pops on empty lists, %0d responses compared, %0d mismatches.",
               n_pop_ok, n_pop_empty, n_checked, n_fail);
      if (n_fail == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

>>> k_way_sorted_merge_core.f
hw/rtl/kwm_pkg.sv
hw/rtl/kwm_dp.sv
hw/rtl/kwm_ctrl.sv
hw/rtl/k_way_sorted_merge_core.sv
tb/tb.sv
